// File: hdl/tml_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tml_pkg
// Shared types, constants and the format-to-tile decoder for the mip level
// layout block.
// ----------------------------------------------------------------------------
package tml_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_SIDE_DEF  = 1024;
  localparam int MAX_LEVEL_DEF = 10;

  // Field widths
  localparam int SIDE_W  = 11;
  localparam int FMT_W   = 6;
  localparam int LOD_W   = 8;
  localparam int LVL_W   = 4;
  localparam int BYTES_W = 23;
  localparam int COLS_W  = 9;   // up to 1024/4 = 256 tiles along a side
  localparam int PROD_W  = 2 * COLS_W;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 96;

  // Texel format codes
  localparam logic [FMT_W-1:0] FMT_I4    = 6'd0;
  localparam logic [FMT_W-1:0] FMT_I8    = 6'd1;
  localparam logic [FMT_W-1:0] FMT_IA4   = 6'd2;
  localparam logic [FMT_W-1:0] FMT_IA8   = 6'd3;
  localparam logic [FMT_W-1:0] FMT_565   = 6'd4;
  localparam logic [FMT_W-1:0] FMT_5A3   = 6'd5;
  localparam logic [FMT_W-1:0] FMT_RGBA8 = 6'd6;
  localparam logic [FMT_W-1:0] FMT_C4    = 6'd8;
  localparam logic [FMT_W-1:0] FMT_C8    = 6'd9;
  localparam logic [FMT_W-1:0] FMT_C14X2 = 6'd10;
  localparam logic [FMT_W-1:0] FMT_CMPR  = 6'd14;
  localparam logic [FMT_W-1:0] FMT_Z8    = 6'd17;
  localparam logic [FMT_W-1:0] FMT_Z16   = 6'd19;
  localparam logic [FMT_W-1:0] FMT_Z24X8 = 6'd22;

  // Tile shape: wide = 8 texels across (else 4), tall = 8 rows (else 4),
  // big = 64 bytes per tile (else 32)
  typedef struct packed {
    logic known;
    logic wide;
    logic tall;
    logic big;
  } tml_shape_t;

  // One input transaction
  typedef struct packed {
    logic [LVL_W-1:0]  level_index;
    logic [LOD_W-1:0]  max_lod;
    logic              mip_enable;
    logic [FMT_W-1:0]  format_code;
    logic [SIDE_W-1:0] tex_height;
    logic [SIDE_W-1:0] tex_width;
  } tml_item_t;

  // One result transaction
  typedef struct packed {
    logic               valid_res;
    logic [LVL_W-1:0]   level_count;
    logic [BYTES_W-1:0] level_offset;
    logic [BYTES_W-1:0] level_bytes;
    logic [SIDE_W-1:0]  level_width;
    logic [SIDE_W-1:0]  level_height;
    logic [BYTES_W-1:0] total_bytes;
  } tml_result_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ACC,
    ST_DONE
  } tml_state_t;

  // Format code to tile shape
  function automatic tml_shape_t tile_shape(input logic [FMT_W-1:0] fmt);
    tml_shape_t s;
    s = '0;
    unique case (fmt) inside
      FMT_I4, FMT_C4, FMT_CMPR: begin
        s = '{known: 1'b1, wide: 1'b1, tall: 1'b1, big: 1'b0};
      end
      FMT_I8, FMT_IA4, FMT_C8, FMT_Z8: begin
        s = '{known: 1'b1, wide: 1'b1, tall: 1'b0, big: 1'b0};
      end
      FMT_IA8, FMT_565, FMT_5A3, FMT_C14X2, FMT_Z16: begin
        s = '{known: 1'b1, wide: 1'b0, tall: 1'b0, big: 1'b0};
      end
      FMT_RGBA8, FMT_Z24X8: begin
        s = '{known: 1'b1, wide: 1'b0, tall: 1'b0, big: 1'b1};
      end
      default: begin
        s = '0;
      end
    endcase
    return s;
  endfunction

endpackage

// File: hdl/tml_level_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tml_level_unit
// Shared size unit: tiles across times tiles down, registered, then scaled
// by the tile size in bytes.
// ----------------------------------------------------------------------------
module tml_level_unit (
  input  logic                         clk,
  input  logic                         mul_en,
  input  logic [tml_pkg::SIDE_W-1:0]   cur_w,
  input  logic [tml_pkg::SIDE_W-1:0]   cur_h,
  input  tml_pkg::tml_shape_t          shape,
  output logic [tml_pkg::BYTES_W-1:0]  level_bytes
);
  import tml_pkg::*;

  logic [COLS_W-1:0] cols;
  logic [COLS_W-1:0] rows;
  logic [PROD_W-1:0] prod_r;
  logic              big_r;

  // Round each side up to whole tiles
  always_comb begin
    if (shape.wide) begin
      cols = COLS_W'((cur_w + SIDE_W'(7)) >> 3);
    end else begin
      cols = COLS_W'((cur_w + SIDE_W'(3)) >> 2);
    end
    if (shape.tall) begin
      rows = COLS_W'((cur_h + SIDE_W'(7)) >> 3);
    end else begin
      rows = COLS_W'((cur_h + SIDE_W'(3)) >> 2);
    end
  end

  // Tile count, registered
  always_ff @(posedge clk) begin
    if (mul_en) begin
      prod_r <= cols * rows;
      big_r  <= shape.big;
    end
  end

  // 32 or 64 bytes per tile
  assign level_bytes = big_r ? (BYTES_W'(prod_r) << 6) : (BYTES_W'(prod_r) << 5);

endmodule

// File: hdl/tml_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tml_ctrl
// Level sequencer: checks the descriptor, walks the mip chain one level per
// pass through the size unit, and collects the requested level.
// ----------------------------------------------------------------------------
module tml_ctrl #(
  parameter int MAX_SIDE  = tml_pkg::MAX_SIDE_DEF,
  parameter int MAX_LEVEL = tml_pkg::MAX_LEVEL_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  tml_pkg::tml_item_t           in_item,
  output logic                         in_ready,
  input  logic                         out_free,
  output logic                         res_load,
  output tml_pkg::tml_result_t         res,
  output logic                         mul_en,
  output logic [tml_pkg::SIDE_W-1:0]   cur_w,
  output logic [tml_pkg::SIDE_W-1:0]   cur_h,
  output tml_pkg::tml_shape_t          shape,
  input  logic [tml_pkg::BYTES_W-1:0]  level_bytes
);
  import tml_pkg::*;

  localparam logic [SIDE_W-1:0] SIDE_LIMIT  = SIDE_W'(MAX_SIDE);
  localparam logic [LVL_W-1:0]  LEVEL_LIMIT = LVL_W'(MAX_LEVEL);

  tml_state_t         state_r, state_nxt;
  logic [SIDE_W-1:0]  w_r, w_nxt;
  logic [SIDE_W-1:0]  h_r, h_nxt;
  tml_shape_t         shape_r, shape_nxt;
  logic [LVL_W-1:0]   lvl_r, lvl_nxt;
  logic [LVL_W-1:0]   req_r, req_nxt;
  logic [LVL_W-1:0]   idx_r, idx_nxt;
  logic [BYTES_W-1:0] off_r, off_nxt;
  tml_result_t        res_r, res_nxt;

  tml_shape_t         in_shape;
  logic               in_ok;
  logic [LVL_W-1:0]   in_req;
  logic [BYTES_W-1:0] off_sum;
  logic               last_level;

  // Descriptor check and requested depth
  always_comb begin
    in_shape = tile_shape(in_item.format_code);
    in_ok    = in_shape.known
               && (in_item.tex_width != '0) && (in_item.tex_height != '0)
               && (in_item.tex_width <= SIDE_LIMIT)
               && (in_item.tex_height <= SIDE_LIMIT);
    if (!in_item.mip_enable) begin
      in_req = '0;
    end else if (in_item.max_lod[LOD_W-1:4] > LEVEL_LIMIT) begin
      in_req = LEVEL_LIMIT;
    end else begin
      in_req = in_item.max_lod[LOD_W-1:4];
    end
  end

  // Chain ends at the requested depth or once both sides reach 1
  assign off_sum    = off_r + level_bytes;
  assign last_level = (idx_r == req_r) || ((w_r == SIDE_W'(1)) && (h_r == SIDE_W'(1)));

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = in_ok ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL: begin
        state_nxt = ST_ACC;
      end
      ST_ACC: begin
        state_nxt = last_level ? ST_DONE : ST_MUL;
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control outputs
  always_comb begin
    in_ready = (state_r == ST_IDLE);
    mul_en   = (state_r == ST_MUL);
    res_load = (state_r == ST_DONE) && out_free;
  end

  // Datapath
  always_comb begin
    w_nxt     = w_r;
    h_nxt     = h_r;
    shape_nxt = shape_r;
    lvl_nxt   = lvl_r;
    req_nxt   = req_r;
    idx_nxt   = idx_r;
    off_nxt   = off_r;
    res_nxt   = res_r;
    if ((state_r == ST_IDLE) && in_valid) begin
      w_nxt     = in_item.tex_width;
      h_nxt     = in_item.tex_height;
      shape_nxt = in_shape;
      lvl_nxt   = in_item.level_index;
      req_nxt   = in_req;
      idx_nxt   = '0;
      off_nxt   = '0;
      res_nxt   = '0;
    end else if (state_r == ST_ACC) begin
      if (idx_r == lvl_r) begin
        res_nxt.valid_res    = 1'b1;
        res_nxt.level_offset = off_r;
        res_nxt.level_bytes  = level_bytes;
        res_nxt.level_width  = w_r;
        res_nxt.level_height = h_r;
      end
      off_nxt = off_sum;
      if (last_level) begin
        res_nxt.level_count = idx_r + LVL_W'(1);
        res_nxt.total_bytes = off_sum;
      end else begin
        idx_nxt = idx_r + LVL_W'(1);
        w_nxt   = (w_r > SIDE_W'(1)) ? (w_r >> 1) : SIDE_W'(1);
        h_nxt   = (h_r > SIDE_W'(1)) ? (h_r >> 1) : SIDE_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    w_r     <= w_nxt;
    h_r     <= h_nxt;
    shape_r <= shape_nxt;
    lvl_r   <= lvl_nxt;
    req_r   <= req_nxt;
    idx_r   <= idx_nxt;
    off_r   <= off_nxt;
    res_r   <= res_nxt;
  end

  assign res   = res_r;
  assign cur_w = w_r;
  assign cur_h = h_r;
  assign shape = shape_r;

endmodule

// File: hdl/texture_mip_level_layout_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texture_mip_level_layout_top
// Mip level layout of a tiled texture: level count, offset, size and sides
// of a requested level, and the total size of the resident chain.
// ----------------------------------------------------------------------------
// One descriptor is taken at a time. A rejected descriptor (unknown format,
// zero side or side above MAX_SIDE) goes straight to the done state and
// reaches the result register from there, and the block turns ready again
// as it loads that result. A valid one passes through the multiply and
// accumulate states once per level, then through the done state into the
// result register. The single tile-count multiplier sets the pace: each level
// passes through it once (multiply, then scale and accumulate). The result
// sits in an output register, so the next descriptor is taken while the
// previous result waits; while that register is still full, a finished
// result holds in the sequencer until the register frees.
module texture_mip_level_layout_top #(
  parameter int MAX_SIDE  = tml_pkg::MAX_SIDE_DEF,
  parameter int MAX_LEVEL = tml_pkg::MAX_LEVEL_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // tex_width[10:0], tex_height[21:11], format_code[27:22], mip_enable[28],
  // max_lod[36:29], level_index[40:37], zero fill [47:41]
  input  logic [47:0] in_tdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  // level_count[3:0], level_offset[26:4], level_bytes[49:27],
  // level_width[60:50], level_height[71:61], total_bytes[94:72], zero [95]
  output logic [95:0] out_tdata,
  // valid_res[0]
  output logic        out_tuser,
  output logic        out_tvalid,
  input  logic        out_tready
);
  import tml_pkg::*;

  tml_item_t          in_item;
  tml_result_t        res;
  tml_result_t        out_res_r;
  logic               out_valid_r;
  logic               out_free;
  logic               res_load;
  logic               mul_en;
  logic [SIDE_W-1:0]  cur_w;
  logic [SIDE_W-1:0]  cur_h;
  tml_shape_t         shape;
  logic [BYTES_W-1:0] level_bytes;

  assign in_item  = tml_item_t'(in_tdata[$bits(tml_item_t)-1:0]);
  assign out_free = !out_valid_r || out_tready;

  tml_ctrl #(
    .MAX_SIDE  (MAX_SIDE),
    .MAX_LEVEL (MAX_LEVEL)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_item     (in_item),
    .in_ready    (in_tready),
    .out_free    (out_free),
    .res_load    (res_load),
    .res         (res),
    .mul_en      (mul_en),
    .cur_w       (cur_w),
    .cur_h       (cur_h),
    .shape       (shape),
    .level_bytes (level_bytes)
  );

  tml_level_unit u_level_unit (
    .clk         (clk),
    .mul_en      (mul_en),
    .cur_w       (cur_w),
    .cur_h       (cur_h),
    .shape       (shape),
    .level_bytes (level_bytes)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_res_r.valid_res;
  assign out_tdata  = {1'b0, out_res_r.total_bytes, out_res_r.level_height,
                       out_res_r.level_width, out_res_r.level_bytes,
                       out_res_r.level_offset, out_res_r.level_count};

  // Not ready in the cycle after each accepted descriptor
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> !in_tready)
    else $error("block ready straight after a descriptor transaction");

  // Level fields are zero when the level is not resident
  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[71:4] == '0))
    else $error("non-zero level fields on an invalid level");

  // A resident level has a non-empty size and non-zero sides
  a_valid_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |->
      ((out_tdata[3:0] != '0) && (out_tdata[49:27] != '0) &&
       (out_tdata[60:50] != '0) && (out_tdata[71:61] != '0)))
    else $error("resident level with zero size or side");

  // A rejected descriptor has no total size
  a_empty_total: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && (out_tdata[3:0] == '0)) |-> (out_tdata[94:72] == '0))
    else $error("non-zero total for an empty chain");

endmodule
